// ----- hdl/pftb_pkg.sv -----
`timescale 1ns / 1ps
package pftb_pkg;

    localparam int SLOT_W     = 16;
    localparam int TOKEN_W    = 19;
    localparam int TIME_W     = 32;
    localparam int ELAPSED_W  = 16;
    localparam int RATE_W     = 12;
    localparam int BURST_W    = 12;
    localparam int SCAP_W     = 13;
    localparam int STALE_W    = 16;
    localparam int IVAL_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int SIXTIETHS  = 60;

    localparam logic [CFG_IDX_W-1:0] CFG_RATE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BURST    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STRICT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STALE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 3'd4;

    localparam logic [RATE_W-1:0]  RST_RATE     = 12'd60;
    localparam logic [BURST_W-1:0] RST_BURST    = 12'd20;
    localparam logic [SCAP_W-1:0]  RST_STRICT   = 13'd8;
    localparam logic [STALE_W-1:0] RST_STALE    = 16'd300;
    localparam logic [IVAL_W-1:0]  RST_INTERVAL = 16'd60;

    typedef struct packed {
        logic [9:0]        flow_index;
        logic [TIME_W-1:0] now_seconds;
        logic              strict;
    } t_in_word;

    typedef struct packed {
        logic               allowed;
        logic [TOKEN_W-1:0] tokens_left;
    } t_out_word;

    typedef struct packed {
        logic [RATE_W-1:0]  rate_per_minute;
        logic [BURST_W-1:0] burst_allowance;
        logic [SCAP_W-1:0]  strict_cap;
        logic [STALE_W-1:0] stale_seconds;
        logic [IVAL_W-1:0]  sweep_interval;
    } t_cfg;

    typedef struct packed {
        logic [SLOT_W-1:0] flow_slot;
        logic [TIME_W-1:0] now_seconds;
        logic              strict;
        logic [TIME_W-1:0] sweep_time;
    } t_task;

    typedef struct packed {
        logic               valid;
        logic [TOKEN_W-1:0] tokens;
        logic [TIME_W-1:0]  refill_time;
        logic [TIME_W-1:0]  seen_time;
    } t_entry;

endpackage

// ----- hdl/per_flow_token_bucket_limiter.sv -----
`timescale 1ns / 1ps
// channel   direction  handshake                    word
// request   in         push / full                  i_req (flow_index, now_seconds, strict)
// result    out        empty / pop                  o_res (allowed, tokens_left)
// config    in         i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// The flow table read-modify-write loop (read, refill multiply, clamp and write back) takes one
// request at a time; the next is popped once the last is written back.
// After reset the flow table is cleared one entry a cycle, all FLOW_ENTRIES entries, with full high.
// A two-word queue sits between classify and update, and another holds results, so a stalled
// pop blocks new requests only once both queues and the front register are full.
module per_flow_token_bucket_limiter
    import pftb_pkg::*;
#(
    parameter int FLOW_ENTRIES = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  t_in_word              i_req,
    output logic                  empty,
    input  logic                  pop,
    output t_out_word             o_res,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg      r_cfg;
    logic      clearing;
    logic      task_push;
    t_task     task_in;
    logic      task_full;
    logic      task_pop;
    t_task     task_out;
    logic      task_empty;
    logic      res_push;
    t_out_word res_in;
    logic      res_full;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rate_per_minute <= RST_RATE;
            r_cfg.burst_allowance <= RST_BURST;
            r_cfg.strict_cap      <= RST_STRICT;
            r_cfg.stale_seconds   <= RST_STALE;
            r_cfg.sweep_interval  <= RST_INTERVAL;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_RATE:     r_cfg.rate_per_minute <= i_cfg_data[RATE_W-1:0];
                CFG_BURST:    r_cfg.burst_allowance <= i_cfg_data[BURST_W-1:0];
                CFG_STRICT:   r_cfg.strict_cap      <= i_cfg_data[SCAP_W-1:0];
                CFG_STALE:    r_cfg.stale_seconds   <= i_cfg_data[STALE_W-1:0];
                CFG_INTERVAL: r_cfg.sweep_interval  <= i_cfg_data[IVAL_W-1:0];
                default:      r_cfg <= r_cfg;
            endcase
        end
    end

    pftb_front #(
        .FLOW_ENTRIES(FLOW_ENTRIES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_busy      (clearing),
        .i_push      (push),
        .i_word      (i_req),
        .o_full      (full),
        .o_task_push (task_push),
        .o_task      (task_in),
        .i_task_full (task_full)
    );

    pftb_fifo #(
        .W($bits(t_task))
    ) u_task_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (task_push),
        .i_data  (task_in),
        .o_full  (task_full),
        .i_pop   (task_pop),
        .o_data  (task_out),
        .o_empty (task_empty)
    );

    pftb_back #(
        .FLOW_ENTRIES(FLOW_ENTRIES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .o_clearing   (clearing),
        .i_task_empty (task_empty),
        .i_task       (task_out),
        .o_task_pop   (task_pop),
        .o_res_push   (res_push),
        .o_res        (res_in),
        .i_res_full   (res_full)
    );

    pftb_fifo #(
        .W($bits(t_out_word))
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (o_res),
        .o_empty (empty)
    );

endmodule

// ----- hdl/pftb_fifo.sv -----
`timescale 1ns / 1ps
module pftb_fifo #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);

    logic [W-1:0] r_mem [2];
    logic         r_wr_ptr;
    logic         r_rd_ptr;
    logic [1:0]   r_count;
    logic         wr_en;
    logic         rd_en;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (rd_en) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({wr_en, rd_en})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- hdl/pftb_front.sv -----
`timescale 1ns / 1ps
module pftb_front
    import pftb_pkg::*;
#(
    parameter int FLOW_ENTRIES = 1024
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_busy,
    input  logic     i_push,
    input  t_in_word i_word,
    output logic     o_full,
    output logic     o_task_push,
    output t_task    o_task,
    input  logic     i_task_full
);

    logic [TIME_W-1:0] r_last_sweep;
    logic [TIME_W-1:0] n_last_sweep;
    logic              r_valid;
    t_in_word          r_item;
    logic [TIME_W-1:0] r_sweep_time;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W:0]   since_sweep;
    logic              accept;

    assign o_full      = i_busy || (r_valid && i_task_full);
    assign accept      = i_push && !o_full;
    assign o_task_push = r_valid && !i_task_full;

    assign since_sweep = {1'b0, i_word.now_seconds} - {1'b0, r_last_sweep};

    always_comb begin
        n_last_sweep = r_last_sweep;
        if (!since_sweep[TIME_W] &&
            since_sweep[TIME_W-1:0] >= TIME_W'(i_cfg.sweep_interval)) begin
            n_last_sweep = i_word.now_seconds;
        end
    end

    generate
        if (FLOW_ENTRIES >= 1024) begin : g_direct
            assign slot = SLOT_W'(r_item.flow_index);
        end else begin : g_wrap
            localparam int RECIP = ((1 << 20) + FLOW_ENTRIES - 1) / FLOW_ENTRIES;
            logic [29:0] quot_prod;
            logic [9:0]  r_quot;
            logic [19:0] back_prod;
            logic [19:0] rem;

            assign quot_prod = 30'(i_word.flow_index) * 30'(RECIP);
            assign back_prod = 20'(r_quot) * 20'(FLOW_ENTRIES);
            assign rem       = 20'(r_item.flow_index) - back_prod;
            assign slot      = rem[SLOT_W-1:0];

            always_ff @(posedge i_clk) begin
                if (accept) begin
                    r_quot <= quot_prod[29:20];
                end
            end
        end
    endgenerate

    always_comb begin
        o_task.flow_slot   = slot;
        o_task.now_seconds = r_item.now_seconds;
        o_task.strict      = r_item.strict;
        o_task.sweep_time  = r_sweep_time;
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item       <= i_word;
            r_sweep_time <= n_last_sweep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_last_sweep <= '0;
        end else begin
            if (accept) begin
                r_valid      <= 1'b1;
                r_last_sweep <= n_last_sweep;
            end else if (o_task_push) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

// ----- hdl/pftb_back.sv -----
`timescale 1ns / 1ps
module pftb_back
    import pftb_pkg::*;
#(
    parameter int FLOW_ENTRIES = 1024
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    output logic      o_clearing,
    input  logic      i_task_empty,
    input  t_task     i_task,
    output logic      o_task_pop,
    output logic      o_res_push,
    output t_out_word o_res,
    input  logic      i_res_full
);

    localparam int IDX_W = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FLOW_ENTRIES - 1);
    localparam int PROD_W = RATE_W + ELAPSED_W;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_WRITE = 3'd4;

    t_entry             r_mem [FLOW_ENTRIES];
    t_entry             r_rd_data;
    logic [2:0]         r_state;
    logic [2:0]         n_state;
    logic [IDX_W-1:0]   r_clr_cnt;
    t_task              r_task;
    logic [TOKEN_W-1:0] r_base;
    logic [TOKEN_W-1:0] r_cap;
    logic [TIME_W-1:0]  r_refill;
    logic [ELAPSED_W-1:0] r_elapsed;
    logic               r_do_refill;
    logic [PROD_W-1:0]  r_prod;

    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    t_entry             mem_wdata;
    logic               rd_en;

    logic [TIME_W:0]    idle_span;
    logic               stale;
    logic               present;
    logic [SCAP_W-1:0]  normal_cap;
    logic [TOKEN_W-1:0] full_tok;
    logic [TOKEN_W-1:0] strict_tok;
    logic [TOKEN_W-1:0] base;
    logic [TIME_W-1:0]  refill_t;
    logic [TIME_W:0]    gap;
    logic               do_refill;
    logic [ELAPSED_W-1:0] elapsed;

    logic [PROD_W:0]    sum;
    logic [TOKEN_W-1:0] refilled;
    logic [TOKEN_W-1:0] tok;
    logic               allowed;
    logic [TOKEN_W-1:0] left;

    assign o_clearing = (r_state == S_CLEAR);
    assign o_task_pop = (r_state == S_IDLE) && !i_task_empty && !i_res_full;
    assign rd_en      = o_task_pop;

    // lookup and refill decision
    assign idle_span  = {1'b0, r_task.sweep_time} - {1'b0, r_rd_data.seen_time};
    assign stale      = !idle_span[TIME_W] &&
                        (idle_span[TIME_W-1:0] > TIME_W'(i_cfg.stale_seconds));
    assign present    = r_rd_data.valid && !stale;
    assign normal_cap = SCAP_W'(i_cfg.rate_per_minute) + SCAP_W'(i_cfg.burst_allowance);
    assign full_tok   = TOKEN_W'(normal_cap) * TOKEN_W'(SIXTIETHS);
    assign strict_tok = TOKEN_W'(i_cfg.strict_cap) * TOKEN_W'(SIXTIETHS);
    assign base       = present ? r_rd_data.tokens : full_tok;
    assign refill_t   = present ? r_rd_data.refill_time : r_task.now_seconds;
    assign gap        = {1'b0, r_task.now_seconds} - {1'b0, refill_t};
    assign do_refill  = !gap[TIME_W] && (gap[TIME_W-1:0] != '0);
    assign elapsed    = (gap[TIME_W-1:ELAPSED_W] != '0) ? '1 : gap[ELAPSED_W-1:0];

    // clamp, decide, spend
    assign sum      = (PROD_W+1)'(r_base) + (PROD_W+1)'(r_prod);
    assign refilled = (sum > (PROD_W+1)'(r_cap)) ? r_cap : sum[TOKEN_W-1:0];
    assign tok      = r_do_refill ? refilled : r_base;
    assign allowed  = (tok >= TOKEN_W'(SIXTIETHS));
    assign left     = allowed ? (tok - TOKEN_W'(SIXTIETHS)) : tok;

    assign o_res_push        = (r_state == S_WRITE);
    assign o_res.allowed     = allowed;
    assign o_res.tokens_left = left;

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_clr_cnt;
        mem_wdata = '0;
        case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
            end
            S_WRITE: begin
                mem_we                = 1'b1;
                mem_waddr             = r_task.flow_slot[IDX_W-1:0];
                mem_wdata.valid       = 1'b1;
                mem_wdata.tokens      = left;
                mem_wdata.refill_time = r_do_refill ? r_task.now_seconds : r_refill;
                mem_wdata.seen_time   = r_task.now_seconds;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_cnt == LAST_IDX) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (o_task_pop) begin
                    n_state = S_READ;
                end
            end
            S_READ:  n_state = S_MUL;
            S_MUL:   n_state = S_WRITE;
            S_WRITE: n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[i_task.flow_slot[IDX_W-1:0]];
            r_task    <= i_task;
        end
        if (r_state == S_READ) begin
            r_base      <= base;
            r_cap       <= r_task.strict ? strict_tok : full_tok;
            r_refill    <= refill_t;
            r_elapsed   <= elapsed;
            r_do_refill <= do_refill;
        end
        if (r_state == S_MUL) begin
            r_prod <= PROD_W'(i_cfg.rate_per_minute) * PROD_W'(r_elapsed);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_cnt <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + IDX_W'(1);
            end
        end
    end

endmodule
